// ===== src/midi_to_usb_event_packetizer_core_assert.svh =====
// Assertion macros for the MIDI to USB event packetizer core
`ifndef MIDI_TO_USB_EVENT_PACKETIZER_CORE_ASSERT_SVH
`define MIDI_TO_USB_EVENT_PACKETIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MTU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("packetizer assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("packetizer assertion failed");

`endif

// ===== src/mtu_pkg.sv =====
// Package: parser states, status bytes and code index numbers of the packetizer
package mtu_pkg;

    localparam int NUM_CABLES_DEF = 16;
    localparam int CABLE_W        = 4;
    localparam int BYTE_W         = 8;
    localparam int CIN_W          = 4;

    typedef enum logic [2:0] {
        ST_UNKNOWN = 3'd0,
        ST_ONE     = 3'd1,
        ST_TWO     = 3'd2,
        ST_TWO_B   = 3'd3,
        ST_SX0     = 3'd4,
        ST_SX1     = 3'd5,
        ST_SX2     = 3'd6
    } t_parse_state;

    localparam logic [BYTE_W-1:0] MIDI_REALTIME_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] MIDI_SYSTEM_MIN   = 8'hF0;
    localparam logic [BYTE_W-1:0] MIDI_STATUS_MIN   = 8'h80;
    localparam logic [BYTE_W-1:0] MIDI_ONE_DATA_LO  = 8'hC0;
    localparam logic [BYTE_W-1:0] MIDI_ONE_DATA_HI  = 8'hDF;
    localparam logic [BYTE_W-1:0] MIDI_SYSEX_START  = 8'hF0;
    localparam logic [BYTE_W-1:0] MIDI_TIME_CODE    = 8'hF1;
    localparam logic [BYTE_W-1:0] MIDI_SONG_POS     = 8'hF2;
    localparam logic [BYTE_W-1:0] MIDI_SONG_SEL     = 8'hF3;
    localparam logic [BYTE_W-1:0] MIDI_TUNE_REQ     = 8'hF6;
    localparam logic [BYTE_W-1:0] MIDI_SYSEX_END    = 8'hF7;

    localparam logic [CIN_W-1:0] CIN_SYSCOM_TWO   = 4'h2;
    localparam logic [CIN_W-1:0] CIN_SYSCOM_THREE = 4'h3;
    localparam logic [CIN_W-1:0] CIN_SYSEX_CONT   = 4'h4;
    localparam logic [CIN_W-1:0] CIN_SYSEX_END1   = 4'h5;
    localparam logic [CIN_W-1:0] CIN_SYSEX_END2   = 4'h6;
    localparam logic [CIN_W-1:0] CIN_SYSEX_END3   = 4'h7;
    localparam logic [CIN_W-1:0] CIN_SINGLE_BYTE  = 4'hF;

endpackage

// ===== src/midi_to_usb_event_packetizer_core.sv =====
// Top level: per-cable MIDI byte parser producing USB-MIDI event packets
// An accepted item is registered in the input stage; its packet then in the output one.
// One item per cycle unless stalled; a parser lookup and update per item sets the rate.
// The input stage stalls only while its item has a packet and the output one is not taken.
// Reset (synchronous, active low) puts every cable parser in the unknown state,
// clears the held bytes and empties both stages.
`include "midi_to_usb_event_packetizer_core_assert.svh"

module midi_to_usb_event_packetizer_core #(
    parameter int NUM_CABLES = mtu_pkg::NUM_CABLES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mtu_pkg::CABLE_W-1:0]  i_cable,
    input  logic [mtu_pkg::BYTE_W-1:0]   i_midi_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mtu_pkg::CABLE_W-1:0]  o_packet_cable,
    output logic [mtu_pkg::CIN_W-1:0]    o_code_index,
    output logic [mtu_pkg::BYTE_W-1:0]   o_event_byte1,
    output logic [mtu_pkg::BYTE_W-1:0]   o_event_byte2,
    output logic [mtu_pkg::BYTE_W-1:0]   o_event_byte3
);
    import mtu_pkg::*;

    localparam int IDX_W = (NUM_CABLES > 1) ? $clog2(NUM_CABLES) : 1;
    localparam logic [CABLE_W:0] CABLE_LIMIT = (CABLE_W + 1)'(NUM_CABLES);

    t_parse_state        r_parse_state [NUM_CABLES];
    logic [BYTE_W-1:0]   r_held_first  [NUM_CABLES];
    logic [BYTE_W-1:0]   r_held_second [NUM_CABLES];

    logic                r_s1_valid;
    logic [CABLE_W-1:0]  r_s1_cable;
    logic [BYTE_W-1:0]   r_s1_byte;

    logic                r_out_valid;
    logic [CABLE_W-1:0]  r_out_cable;
    logic [CIN_W-1:0]    r_out_cin;
    logic [BYTE_W-1:0]   r_out_b1;
    logic [BYTE_W-1:0]   r_out_b2;
    logic [BYTE_W-1:0]   r_out_b3;

    logic [IDX_W-1:0]    s1_idx;
    logic                s1_in_range;
    t_parse_state        cur_st;
    logic [BYTE_W-1:0]   cur_h0;
    logic [BYTE_W-1:0]   cur_h1;

    t_parse_state        n_st;
    logic [BYTE_W-1:0]   n_h0;
    logic [BYTE_W-1:0]   n_h1;

    logic                s1_has;
    logic [CIN_W-1:0]    s1_cin;
    logic [BYTE_W-1:0]   s1_b1;
    logic [BYTE_W-1:0]   s1_b2;
    logic [BYTE_W-1:0]   s1_b3;
    logic                s1_adv;

    assign s1_idx      = r_s1_cable[IDX_W-1:0];
    assign s1_in_range = {1'b0, r_s1_cable} < CABLE_LIMIT;
    assign cur_st      = r_parse_state[s1_idx];
    assign cur_h0      = r_held_first[s1_idx];
    assign cur_h1      = r_held_second[s1_idx];

    // next parser state
    always_comb begin
        n_st = cur_st;
        n_h0 = cur_h0;
        n_h1 = cur_h1;
        if (r_s1_byte >= MIDI_REALTIME_MIN) begin
            n_st = cur_st;
        end else if (r_s1_byte >= MIDI_SYSTEM_MIN) begin
            case (r_s1_byte)
                MIDI_SYSEX_START: begin
                    n_h0 = r_s1_byte;
                    n_st = ST_SX1;
                end
                MIDI_TIME_CODE, MIDI_SONG_SEL: begin
                    n_h0 = r_s1_byte;
                    n_st = ST_ONE;
                end
                MIDI_SONG_POS: begin
                    n_h0 = r_s1_byte;
                    n_st = ST_TWO;
                end
                default: begin
                    n_st = ST_UNKNOWN;
                end
            endcase
        end else if (r_s1_byte >= MIDI_STATUS_MIN) begin
            n_h0 = r_s1_byte;
            n_st = (r_s1_byte inside {[MIDI_ONE_DATA_LO:MIDI_ONE_DATA_HI]}) ? ST_ONE : ST_TWO;
        end else begin
            case (cur_st)
                ST_ONE: begin
                    if (cur_h0 >= MIDI_SYSTEM_MIN) begin
                        n_st = ST_UNKNOWN;
                    end
                end
                ST_TWO: begin
                    n_h1 = r_s1_byte;
                    n_st = ST_TWO_B;
                end
                ST_TWO_B: begin
                    n_st = (cur_h0 < MIDI_SYSTEM_MIN) ? ST_TWO : ST_UNKNOWN;
                end
                ST_SX0: begin
                    n_h0 = r_s1_byte;
                    n_st = ST_SX1;
                end
                ST_SX1: begin
                    n_h1 = r_s1_byte;
                    n_st = ST_SX2;
                end
                ST_SX2: begin
                    n_st = ST_SX0;
                end
                default: begin
                    n_st = cur_st;
                end
            endcase
        end
    end

    // event packet
    always_comb begin
        s1_has = 1'b0;
        s1_cin = '0;
        s1_b1  = '0;
        s1_b2  = '0;
        s1_b3  = '0;
        if (r_s1_byte >= MIDI_REALTIME_MIN) begin
            s1_has = 1'b1;
            s1_cin = CIN_SINGLE_BYTE;
            s1_b1  = r_s1_byte;
        end else if (r_s1_byte >= MIDI_SYSTEM_MIN) begin
            if (r_s1_byte == MIDI_TUNE_REQ) begin
                s1_has = 1'b1;
                s1_cin = CIN_SYSEX_END1;
                s1_b1  = MIDI_TUNE_REQ;
            end else if (r_s1_byte == MIDI_SYSEX_END) begin
                case (cur_st)
                    ST_SX0: begin
                        s1_has = 1'b1;
                        s1_cin = CIN_SYSEX_END1;
                        s1_b1  = MIDI_SYSEX_END;
                    end
                    ST_SX1: begin
                        s1_has = 1'b1;
                        s1_cin = CIN_SYSEX_END2;
                        s1_b1  = cur_h0;
                        s1_b2  = MIDI_SYSEX_END;
                    end
                    ST_SX2: begin
                        s1_has = 1'b1;
                        s1_cin = CIN_SYSEX_END3;
                        s1_b1  = cur_h0;
                        s1_b2  = cur_h1;
                        s1_b3  = MIDI_SYSEX_END;
                    end
                    default: begin
                        s1_has = 1'b0;
                    end
                endcase
            end
        end else if (r_s1_byte < MIDI_STATUS_MIN) begin
            case (cur_st)
                ST_ONE: begin
                    s1_has = 1'b1;
                    s1_cin = (cur_h0 < MIDI_SYSTEM_MIN) ? cur_h0[7:4] : CIN_SYSCOM_TWO;
                    s1_b1  = cur_h0;
                    s1_b2  = r_s1_byte;
                end
                ST_TWO_B: begin
                    s1_has = 1'b1;
                    s1_cin = (cur_h0 < MIDI_SYSTEM_MIN) ? cur_h0[7:4] : CIN_SYSCOM_THREE;
                    s1_b1  = cur_h0;
                    s1_b2  = cur_h1;
                    s1_b3  = r_s1_byte;
                end
                ST_SX2: begin
                    s1_has = 1'b1;
                    s1_cin = CIN_SYSEX_CONT;
                    s1_b1  = cur_h0;
                    s1_b2  = cur_h1;
                    s1_b3  = r_s1_byte;
                end
                default: begin
                    s1_has = 1'b0;
                end
            endcase
        end
        if (!s1_in_range) begin
            s1_has = 1'b0;
        end
    end

    assign s1_adv     = r_s1_valid && (!s1_has || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_cable <= i_cable;
            r_s1_byte  <= i_midi_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CABLES; i++) begin
                r_parse_state[i] <= ST_UNKNOWN;
                r_held_first[i]  <= '0;
                r_held_second[i] <= '0;
            end
        end else if (s1_adv && s1_in_range) begin
            r_parse_state[s1_idx] <= n_st;
            r_held_first[s1_idx]  <= n_h0;
            r_held_second[s1_idx] <= n_h1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && s1_has) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_has) begin
            r_out_cable <= r_s1_cable;
            r_out_cin   <= s1_cin;
            r_out_b1    <= s1_b1;
            r_out_b2    <= s1_b2;
            r_out_b3    <= s1_b3;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_packet_cable = r_out_cable;
    assign o_code_index   = r_out_cin;
    assign o_event_byte1  = r_out_b1;
    assign o_event_byte2  = r_out_b2;
    assign o_event_byte3  = r_out_b3;

    `MTU_ASSERT_NEXT(a_result_loads_output, s1_adv && s1_has, r_out_valid)
    `MTU_ASSERT_NOW(a_out_of_range_silent, r_s1_valid && !s1_in_range, !s1_has)
    `MTU_ASSERT_NOW(a_realtime_packet, o_out_valid && (o_code_index == CIN_SINGLE_BYTE), (o_event_byte1 >= MIDI_REALTIME_MIN) && (o_event_byte2 == '0) && (o_event_byte3 == '0))
    `MTU_ASSERT_NOW(a_sysex_end3_packet, o_out_valid && (o_code_index == CIN_SYSEX_END3), o_event_byte3 == MIDI_SYSEX_END)

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the MIDI to USB event packetizer: directed table, random byte streams, checks
module tb;
    import mtu_pkg::*;

    localparam int N_DIRECTED  = 26;
    localparam int ITEM_TARGET = 1450;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CIN_W-1:0] CIN_NOTE_OFF      = 4'h8;
    localparam logic [CIN_W-1:0] CIN_CHAN_PRESSURE = 4'hD;

    typedef struct packed {
        logic [CABLE_W-1:0] cable;
        logic [CIN_W-1:0]   cin;
        logic [BYTE_W-1:0]  b1;
        logic [BYTE_W-1:0]  b2;
        logic [BYTE_W-1:0]  b3;
    } t_event_pkt;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_PACKET
    } t_row_kind;

    typedef struct packed {
        logic [CABLE_W-1:0] cable;
        logic [BYTE_W-1:0]  byt;
        t_row_kind          kind;
        logic [CIN_W-1:0]   cin;
        logic [BYTE_W-1:0]  b1;
        logic [BYTE_W-1:0]  b2;
        logic [BYTE_W-1:0]  b3;
    } t_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [CABLE_W-1:0] i_cable     = '0;
    logic [BYTE_W-1:0]  i_midi_byte = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [CABLE_W-1:0] o_packet_cable;
    logic [CIN_W-1:0]   o_code_index;
    logic [BYTE_W-1:0]  o_event_byte1;
    logic [BYTE_W-1:0]  o_event_byte2;
    logic [BYTE_W-1:0]  o_event_byte3;

    t_parse_state      cab_state  [NUM_CABLES_DEF];
    logic [BYTE_W-1:0] cab_first  [NUM_CABLES_DEF];
    logic [BYTE_W-1:0] cab_second [NUM_CABLES_DEF];

    t_event_pkt packets_due [$];
    int         bad_packets = 0;
    int         idle_cycles = 0;
    bit         tx_calm     = 1'b0;
    bit         rx_calm     = 1'b0;
    bit         hold_req    = 1'b0;

    t_row opening_rows [0:N_DIRECTED-1] = '{
        '{4'd0,  8'h45, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd0,  8'hFF, ROW_PACKET,  CIN_SINGLE_BYTE,  8'hFF, 8'h00, 8'h00},
        '{4'd15, 8'h80, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd15, 8'h00, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd15, 8'h7F, ROW_PACKET,  CIN_NOTE_OFF,     8'h80, 8'h00, 8'h7F},
        '{4'd3,  8'hDF, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd3,  8'h7F, ROW_PACKET,  CIN_CHAN_PRESSURE, 8'hDF, 8'h7F, 8'h00},
        '{4'd3,  8'h00, ROW_PREDICT, 4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd3,  8'hF4, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd3,  8'h10, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd1,  8'hF0, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd1,  8'h01, ROW_PREDICT, 4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd1,  8'h02, ROW_PACKET,  CIN_SYSEX_CONT,   8'hF0, 8'h01, 8'h02},
        '{4'd1,  8'hF7, ROW_PACKET,  CIN_SYSEX_END1,   8'hF7, 8'h00, 8'h00},
        '{4'd2,  8'hF0, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd2,  8'hF7, ROW_PACKET,  CIN_SYSEX_END2,   8'hF0, 8'hF7, 8'h00},
        '{4'd2,  8'hF7, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd4,  8'hF6, ROW_PACKET,  CIN_SYSEX_END1,   8'hF6, 8'h00, 8'h00},
        '{4'd4,  8'hF1, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd4,  8'h7F, ROW_PACKET,  CIN_SYSCOM_TWO,   8'hF1, 8'h7F, 8'h00},
        '{4'd5,  8'hF2, ROW_PREDICT, 4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd5,  8'h00, ROW_PREDICT, 4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd5,  8'h7F, ROW_PACKET,  CIN_SYSCOM_THREE, 8'hF2, 8'h00, 8'h7F},
        '{4'd6,  8'hF0, ROW_NONE,    4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd6,  8'h55, ROW_PREDICT, 4'h0,             8'h00, 8'h00, 8'h00},
        '{4'd6,  8'hF7, ROW_PACKET,  CIN_SYSEX_END3,   8'hF0, 8'h55, 8'hF7}
    };

    midi_to_usb_event_packetizer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cable        (i_cable),
        .i_midi_byte    (i_midi_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packet_cable (o_packet_cable),
        .o_code_index   (o_code_index),
        .o_event_byte1  (o_event_byte1),
        .o_event_byte2  (o_event_byte2),
        .o_event_byte3  (o_event_byte3)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit encode_event(input logic [CABLE_W-1:0] c,
                                        input logic [BYTE_W-1:0] b,
                                        output t_event_pkt p);
        t_parse_state      st;
        logic [BYTE_W-1:0] h0;
        logic [BYTE_W-1:0] h1;
        bit                got;
        st  = cab_state[c];
        h0  = cab_first[c];
        h1  = cab_second[c];
        p   = '{c, 4'h0, 8'h00, 8'h00, 8'h00};
        got = 1'b0;
        if (b >= MIDI_REALTIME_MIN) begin
            p.cin = CIN_SINGLE_BYTE;
            p.b1  = b;
            got   = 1'b1;
        end else if (b >= MIDI_SYSTEM_MIN) begin
            cab_state[c] = ST_UNKNOWN;
            case (b)
                MIDI_SYSEX_START: begin
                    cab_first[c] = b;
                    cab_state[c] = ST_SX1;
                end
                MIDI_TIME_CODE, MIDI_SONG_SEL: begin
                    cab_first[c] = b;
                    cab_state[c] = ST_ONE;
                end
                MIDI_SONG_POS: begin
                    cab_first[c] = b;
                    cab_state[c] = ST_TWO;
                end
                MIDI_TUNE_REQ: begin
                    p.cin = CIN_SYSEX_END1;
                    p.b1  = b;
                    got   = 1'b1;
                end
                MIDI_SYSEX_END: begin
                    got = 1'b1;
                    if (st == ST_SX0) begin
                        p.cin = CIN_SYSEX_END1;
                        p.b1  = b;
                    end else if (st == ST_SX1) begin
                        p.cin = CIN_SYSEX_END2;
                        p.b1  = h0;
                        p.b2  = b;
                    end else if (st == ST_SX2) begin
                        p.cin = CIN_SYSEX_END3;
                        p.b1  = h0;
                        p.b2  = h1;
                        p.b3  = b;
                    end else begin
                        got = 1'b0;
                    end
                end
                default: ;
            endcase
        end else if (b >= MIDI_STATUS_MIN) begin
            cab_first[c] = b;
            cab_state[c] = (b >= MIDI_ONE_DATA_LO && b <= MIDI_ONE_DATA_HI) ? ST_ONE : ST_TWO;
        end else begin
            case (st)
                ST_ONE: begin
                    got  = 1'b1;
                    p.b1 = h0;
                    p.b2 = b;
                    if (h0 < MIDI_SYSTEM_MIN) begin
                        p.cin = h0[7:4];
                    end else begin
                        p.cin        = CIN_SYSCOM_TWO;
                        cab_state[c] = ST_UNKNOWN;
                    end
                end
                ST_TWO: begin
                    cab_second[c] = b;
                    cab_state[c]  = ST_TWO_B;
                end
                ST_TWO_B: begin
                    got  = 1'b1;
                    p.b1 = h0;
                    p.b2 = h1;
                    p.b3 = b;
                    if (h0 < MIDI_SYSTEM_MIN) begin
                        p.cin        = h0[7:4];
                        cab_state[c] = ST_TWO;
                    end else begin
                        p.cin        = CIN_SYSCOM_THREE;
                        cab_state[c] = ST_UNKNOWN;
                    end
                end
                ST_SX0: begin
                    cab_first[c] = b;
                    cab_state[c] = ST_SX1;
                end
                ST_SX1: begin
                    cab_second[c] = b;
                    cab_state[c]  = ST_SX2;
                end
                ST_SX2: begin
                    got          = 1'b1;
                    p.cin        = CIN_SYSEX_CONT;
                    p.b1         = h0;
                    p.b2         = h1;
                    p.b3         = b;
                    cab_state[c] = ST_SX0;
                end
                default: ;
            endcase
        end
        return got;
    endfunction

    task automatic send_byte(input logic [CABLE_W-1:0] c, input logic [BYTE_W-1:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cable     <= c;
        i_midi_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic put(input logic [CABLE_W-1:0] c, input logic [BYTE_W-1:0] b);
        t_event_pkt p;
        send_byte(c, b);
        if (encode_event(c, b, p)) packets_due.push_back(p);
    endtask

    // cut in with a real-time byte on the same cable or any byte on another cable
    task automatic maybe_cut_in(input logic [CABLE_W-1:0] c, inout int n_sent);
        logic [CABLE_W-1:0] other;
        int                 r;
        r     = $urandom_range(0, 15);
        other = c ^ CABLE_W'($urandom_range(1, 15));
        if (r == 0) begin
            put(c, BYTE_W'($urandom_range(MIDI_REALTIME_MIN, 8'hFF)));
            n_sent++;
        end else if (r == 1) begin
            put(other, BYTE_W'($urandom_range(0, 255)));
            n_sent++;
        end
    endtask

    task automatic note_error(input string msg);
        bad_packets++;
        if (bad_packets <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_event_pkt got;
        t_event_pkt want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_packet_cable, o_code_index, o_event_byte1, o_event_byte2, o_event_byte3};
            if (packets_due.size() == 0) begin
                note_error($sformatf("unexpected packet: cable %0d cin %h bytes %h %h %h",
                                     got.cable, got.cin, got.b1, got.b2, got.b3));
            end else begin
                want = packets_due.pop_front();
                if (got.cable !== want.cable || got.cin !== want.cin || got.b1 !== want.b1
                        || got.b2 !== want.b2 || got.b3 !== want.b3) begin
                    note_error($sformatf({"bad packet: want cable %0d cin %h bytes %h %h %h,",
                                          " got cable %0d cin %h bytes %h %h %h"},
                                         want.cable, want.cin, want.b1, want.b2, want.b3,
                                         got.cable, got.cin, got.b1, got.b2, got.b3));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall    = hold_req ? HOLD_CYCLES : (rx_calm ? 0 : $urandom_range(0, 5));
            hold_req = 1'b0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        t_event_pkt         p;
        t_row               row;
        logic [CABLE_W-1:0] c;
        logic [BYTE_W-1:0]  status;
        int                 i;
        int                 j;
        int                 k;
        int                 n_data;
        int                 reps;
        int                 len;
        int                 kind;
        int                 n_sent;
        int                 mode_switch;
        bit                 held_once;

        for (i = 0; i < NUM_CABLES_DEF; i++) begin
            cab_state[i]  = ST_UNKNOWN;
            cab_first[i]  = '0;
            cab_second[i] = '0;
        end
        n_sent      = 0;
        mode_switch = 0;
        held_once   = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            row = opening_rows[i];
            send_byte(row.cable, row.byt);
            n_sent++;
            if (encode_event(row.cable, row.byt, p) && row.kind == ROW_PREDICT)
                packets_due.push_back(p);
            if (row.kind == ROW_PACKET)
                packets_due.push_back('{row.cable, row.cin, row.b1, row.b2, row.b3});
        end

        while (n_sent < ITEM_TARGET) begin
            if (n_sent >= mode_switch) begin
                tx_calm     = ($urandom_range(0, 3) == 0);
                rx_calm     = ($urandom_range(0, 3) == 0);
                mode_switch = n_sent + $urandom_range(30, 90);
            end
            // stall the receiver while real-time bytes keep coming
            if (!held_once && n_sent >= ITEM_TARGET / 2) begin
                held_once = 1'b1;
                hold_req  = 1'b1;
                tx_calm   = 1'b1;
                repeat (60) begin
                    put(CABLE_W'($urandom_range(0, 15)),
                        BYTE_W'($urandom_range(MIDI_REALTIME_MIN, 8'hFF)));
                    n_sent++;
                end
            end
            c    = CABLE_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                status = BYTE_W'($urandom_range(MIDI_STATUS_MIN, 8'hEF));
                n_data = (status >= MIDI_ONE_DATA_LO && status <= MIDI_ONE_DATA_HI) ? 1 : 2;
                if ($urandom_range(0, 5) != 0) begin
                    put(c, status);
                    n_sent++;
                end
                reps = $urandom_range(1, 3);
                for (j = 0; j < reps; j++) begin
                    for (k = 0; k < n_data; k++) begin
                        put(c, BYTE_W'($urandom_range(0, 8'h7F)));
                        n_sent++;
                        maybe_cut_in(c, n_sent);
                    end
                end
            end else if (kind < 62) begin
                case ($urandom_range(0, 3))
                    0: status = MIDI_TIME_CODE;
                    1: status = MIDI_SONG_SEL;
                    2: status = MIDI_SONG_POS;
                    default: status = MIDI_TUNE_REQ;
                endcase
                put(c, status);
                n_sent++;
                n_data = (status == MIDI_SONG_POS) ? 2 : (status == MIDI_TUNE_REQ) ? 0 : 1;
                for (k = 0; k < n_data; k++) begin
                    maybe_cut_in(c, n_sent);
                    put(c, BYTE_W'($urandom_range(0, 8'h7F)));
                    n_sent++;
                end
            end else if (kind < 82) begin
                put(c, MIDI_SYSEX_START);
                n_sent++;
                len = $urandom_range(0, 8);
                for (k = 0; k < len; k++) begin
                    put(c, BYTE_W'($urandom_range(0, 8'h7F)));
                    n_sent++;
                    maybe_cut_in(c, n_sent);
                end
                // end most dumps properly, break off the rest with another status
                if ($urandom_range(0, 7) != 0)
                    put(c, MIDI_SYSEX_END);
                else
                    put(c, BYTE_W'($urandom_range(MIDI_STATUS_MIN, MIDI_TUNE_REQ)));
                n_sent++;
            end else if (kind < 88) begin
                put(c, BYTE_W'($urandom_range(MIDI_REALTIME_MIN, 8'hFF)));
                n_sent++;
            end else if (kind < 92) begin
                put(c, $urandom_range(0, 1) ? 8'hF4 : 8'hF5);
                n_sent++;
            end else begin
                put(CABLE_W'($urandom_range(0, 15)), BYTE_W'($urandom_range(0, 255)));
                n_sent++;
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (packets_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (bad_packets == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/mtu_pkg.sv
src/midi_to_usb_event_packetizer_core.sv
tb/sv/tb.sv
